// File: src/rbe_pkg.sv
// shared types, constants and codes of the rsa block encryption core
package rbe_pkg;

  localparam int MOD_WIDTH    = 32;
  localparam int EXP_WIDTH    = 32;
  localparam int CIPHER_WIDTH = 32;
  localparam int CHAR_WIDTH   = 8;
  localparam int DIGITS       = 4;
  localparam int CHAR_OFFSET  = 65;
  localparam int DIGIT_BASE   = 100;
  // largest packed block is 99999999, which needs 27 bits
  localparam int BLOCK_W      = 27;
  // multiplier operand carries either a packed block or a residue
  localparam int OP_W         = (MOD_WIDTH > BLOCK_W) ? MOD_WIDTH : BLOCK_W;
  localparam int CNT_W        = $clog2(OP_W);
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PUBLIC_EXPONENT = 1'b0,
    REG_MODULUS         = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REDUCE,
    ST_BIT,
    ST_MUL,
    ST_SQR,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] char_first;
    logic [CHAR_WIDTH-1:0] char_second;
    logic [CHAR_WIDTH-1:0] char_third;
    logic [CHAR_WIDTH-1:0] char_fourth;
  } in_item_t;

  typedef struct packed {
    logic [CIPHER_WIDTH-1:0] ciphertext;
    logic                    invalid_char;
  } out_item_t;

  // request to the shared modular multiplier
  typedef struct packed {
    logic                 start;
    logic [OP_W-1:0]      a;
    logic [MOD_WIDTH-1:0] b;
  } mm_req_t;

endpackage

// File: src/rbe_digit_pack.sv
// character check and base-100 packing of one four-character block
module rbe_digit_pack (
  input  rbe_pkg::in_item_t            item_i,
  output logic [rbe_pkg::BLOCK_W-1:0]  block_o,
  output logic                         invalid_o
);

  logic [rbe_pkg::CHAR_WIDTH-1:0] codes [rbe_pkg::DIGITS];

  assign codes[0] = item_i.char_first;
  assign codes[1] = item_i.char_second;
  assign codes[2] = item_i.char_third;
  assign codes[3] = item_i.char_fourth;

  always_comb begin
    logic [rbe_pkg::BLOCK_W-1:0]    blk;
    logic                           bad;
    logic [rbe_pkg::CHAR_WIDTH-1:0] digit;
    blk = '0;
    bad = 1'b0;
    for (int i = 0; i < rbe_pkg::DIGITS; i++) begin
      digit = codes[i] - rbe_pkg::CHAR_WIDTH'(rbe_pkg::CHAR_OFFSET);
      if ((codes[i] < rbe_pkg::CHAR_WIDTH'(rbe_pkg::CHAR_OFFSET)) ||
          (digit >= rbe_pkg::CHAR_WIDTH'(rbe_pkg::DIGIT_BASE))) begin
        bad = 1'b1;
      end
      // horner step, four narrow steps
      blk = rbe_pkg::BLOCK_W'(blk * rbe_pkg::BLOCK_W'(rbe_pkg::DIGIT_BASE))
          + rbe_pkg::BLOCK_W'(digit);
    end
    block_o   = blk;
    invalid_o = bad;
  end

endmodule

// File: src/rbe_modmul.sv
// bit-serial interleaved modular multiplier, one operand bit per cycle
module rbe_modmul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rbe_pkg::mm_req_t                req_i,
  input  logic [rbe_pkg::MOD_WIDTH-1:0]   n_i,
  output logic                            done_o,
  output logic [rbe_pkg::MOD_WIDTH-1:0]   res_o
);

  localparam int W2 = rbe_pkg::MOD_WIDTH + 2;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [rbe_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [rbe_pkg::OP_W-1:0]      a_q, a_d;
  logic [rbe_pkg::MOD_WIDTH-1:0] b_q, b_d;
  logic [rbe_pkg::MOD_WIDTH-1:0] n_q, n_d;
  logic [rbe_pkg::MOD_WIDTH-1:0] r_q, r_d;

  logic [W2-1:0] t0, t1, t2, n_ext;

  // r = 2r + bit*b, then at most two subtractions of n (b never exceeds n)
  always_comb begin
    n_ext = W2'(n_q);
    t0    = (W2'(r_q) << 1) + (a_q[rbe_pkg::OP_W-1] ? W2'(b_q) : '0);
    t1    = (t0 >= n_ext) ? t0 - n_ext : t0;
    t2    = (t1 >= n_ext) ? t1 - n_ext : t1;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    n_d    = n_q;
    r_d    = r_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = rbe_pkg::CNT_W'(rbe_pkg::OP_W - 1);
      a_d    = req_i.a;
      b_d    = req_i.b;
      n_d    = n_i;
      r_d    = '0;
    end else if (busy_q) begin
      r_d   = t2[rbe_pkg::MOD_WIDTH-1:0];
      a_d   = a_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    a_q   <= a_d;
    b_q   <= b_d;
    n_q   <= n_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q;

  // a new product is only requested while the unit is free
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("modmul started while busy");

  // a finished product is fully reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> (r_q < n_q))
    else $error("modmul result not reduced");

  // the running remainder stays below the modulus while working
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !$rose(busy_q)) |-> (r_q < n_q))
    else $error("modmul remainder out of range");

endmodule

// File: src/rsa_block_encrypt_core.sv
// top level of the rsa block encryption core: registers, sequencer, output stage
//
// Each input transaction carries four character codes; each code minus 65
// is a base-100 digit and the four digits are packed most significant first.
// The core returns one result transaction per input: the packed block raised
// to public_exponent modulo modulus, computed by right-to-left
// square-and-multiply. Any code outside 65..164 gives invalid_char = 1 and
// ciphertext 0; an exponent of zero gives ciphertext 1; a zero modulus with
// a nonzero exponent gives 0. All modular work runs on one bit-serial
// multiplier. For an exponent of bit length m with k one bits, an item takes
// one reduction, k multiplies and m - 1 squarings. The core takes no new
// item while one is in progress, but a finished result waits in the output
// register without blocking the next item. Configuration writes (index 0
// exponent, index 1 modulus) take effect at once and must only be issued
// while the core is idle.
module rsa_block_encrypt_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [rbe_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rbe_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input transactions
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rbe_pkg::in_item_t                  in_data_i,
  // result transactions
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rbe_pkg::out_item_t                 out_data_o
);

  // configuration registers
  logic [rbe_pkg::EXP_WIDTH-1:0] exponent_cfg_q;
  logic [rbe_pkg::MOD_WIDTH-1:0] modulus_cfg_q;

  // sequencer
  rbe_pkg::seq_state_e state_q, state_d;

  // working registers
  logic [rbe_pkg::BLOCK_W-1:0]      block_q;
  logic                             bad_q;
  logic [rbe_pkg::EXP_WIDTH-1:0]    exp_q;
  logic [rbe_pkg::MOD_WIDTH-1:0]    acc_q;
  logic [rbe_pkg::MOD_WIDTH-1:0]    sq_q;
  logic [rbe_pkg::CIPHER_WIDTH-1:0] res_q;

  // output stage
  logic               out_valid_q;
  rbe_pkg::out_item_t out_data_q;

  // packing and multiplier hookup
  logic [rbe_pkg::BLOCK_W-1:0]   pack_block;
  logic                          pack_bad;
  rbe_pkg::mm_req_t              mm_req;
  logic                          mm_done;
  logic [rbe_pkg::MOD_WIDTH-1:0] mm_res;

  logic in_fire;
  logic out_free;
  logic trivial;
  logic last_bit;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  // results that need no arithmetic
  assign trivial  = bad_q || (exp_q == '0) || (modulus_cfg_q == '0);
  // no exponent bits left above the current one
  assign last_bit = (exp_q >> 1) == '0;

  rbe_digit_pack u_pack (
    .item_i    (in_data_i),
    .block_o   (pack_block),
    .invalid_o (pack_bad)
  );

  rbe_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .n_i    (modulus_cfg_q),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_cfg_q <= rbe_pkg::EXP_WIDTH'(1);
      modulus_cfg_q  <= rbe_pkg::MOD_WIDTH'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbe_pkg::REG_PUBLIC_EXPONENT: exponent_cfg_q <= cfg_wdata_i[rbe_pkg::EXP_WIDTH-1:0];
        rbe_pkg::REG_MODULUS:         modulus_cfg_q  <= cfg_wdata_i[rbe_pkg::MOD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rbe_pkg::ST_IDLE:   if (in_valid_i) state_d = rbe_pkg::ST_LOAD;
      rbe_pkg::ST_LOAD:   state_d = trivial ? rbe_pkg::ST_OUT : rbe_pkg::ST_REDUCE;
      rbe_pkg::ST_REDUCE: if (mm_done) state_d = rbe_pkg::ST_BIT;
      rbe_pkg::ST_BIT:    state_d = exp_q[0] ? rbe_pkg::ST_MUL : rbe_pkg::ST_SQR;
      rbe_pkg::ST_MUL: begin
        if (mm_done) state_d = last_bit ? rbe_pkg::ST_OUT : rbe_pkg::ST_SQR;
      end
      rbe_pkg::ST_SQR:    if (mm_done) state_d = rbe_pkg::ST_BIT;
      rbe_pkg::ST_OUT:    if (out_free) state_d = rbe_pkg::ST_IDLE;
      default:            state_d = rbe_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier requests
  always_comb begin
    in_ready_o   = 1'b0;
    mm_req.start = 1'b0;
    mm_req.a     = rbe_pkg::OP_W'(sq_q);
    mm_req.b     = sq_q;
    unique case (state_q)
      rbe_pkg::ST_IDLE: in_ready_o = 1'b1;
      rbe_pkg::ST_LOAD: begin
        // block mod n as block * 1
        mm_req.start = !trivial;
        mm_req.a     = rbe_pkg::OP_W'(block_q);
        mm_req.b     = rbe_pkg::MOD_WIDTH'(1);
      end
      rbe_pkg::ST_BIT: begin
        mm_req.start = 1'b1;
        if (exp_q[0]) begin
          mm_req.a = rbe_pkg::OP_W'(acc_q);
        end
      end
      rbe_pkg::ST_MUL: mm_req.start = mm_done && !last_bit;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbe_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rbe_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      block_q <= pack_block;
      bad_q   <= pack_bad;
      exp_q   <= exponent_cfg_q;
    end
    unique case (state_q)
      rbe_pkg::ST_LOAD: begin
        res_q <= (!bad_q && exp_q == '0) ? rbe_pkg::CIPHER_WIDTH'(1) : '0;
      end
      rbe_pkg::ST_REDUCE: begin
        if (mm_done) begin
          sq_q  <= mm_res;
          acc_q <= rbe_pkg::MOD_WIDTH'(1);
        end
      end
      rbe_pkg::ST_MUL: begin
        if (mm_done) begin
          acc_q <= mm_res;
          res_q <= rbe_pkg::CIPHER_WIDTH'(mm_res);
        end
      end
      rbe_pkg::ST_SQR: begin
        if (mm_done) begin
          sq_q  <= mm_res;
          exp_q <= exp_q >> 1;
        end
      end
      rbe_pkg::ST_OUT: begin
        if (out_free) begin
          out_data_q.ciphertext   <= res_q;
          out_data_q.invalid_char <= bad_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a multiply step is only issued with exponent bits left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbe_pkg::ST_MUL) |-> (exp_q != '0))
    else $error("multiply step with empty exponent");

  // a waiting result stays offered and unchanged until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("waiting result dropped or changed");

  // no second input transaction while an item is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input taken while busy");

endmodule

// File: bench/rsa_block_encrypt_core_test.sv
// testbench for rsa_block_encrypt_core: random and edge traffic checked against a local predictor
`timescale 1ns / 100ps

module rsa_block_encrypt_core_test;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int TAIL_CYCLES  = 3500;
  // percent of cycles in which each side holds back
  localparam int IDLE_PCT     = 32;
  // transaction counts between which neither side holds back
  localparam int STEADY_LO    = 120;
  localparam int STEADY_HI    = 180;
  localparam int RANDOM_PHASES = 10;

  // block value 0, largest block, every code just outside 65..164 in each
  // position, and all-zero / all-one codes
  localparam logic [31:0] EDGE_CODES [14] = '{
    32'h41414141, 32'hA4A4A4A4, 32'h41A44A73, 32'hA4414141,
    32'h40414141, 32'h41404141, 32'h41414041, 32'h41414140,
    32'hA5414141, 32'h41A54141, 32'h4141A541, 32'h414141A5,
    32'h00000000, 32'hFFFFFFFF
  };

  // expected ciphertexts, kept in order of acceptance
  class cipher_scoreboard;
    rbe_pkg::out_item_t expected_q[$];
    logic [31:0]        exponent;
    logic [31:0]        modulus;
    int unsigned        failures;
    int unsigned        inputs_seen;
    int unsigned        results_seen;

    function new();
      exponent = 32'd1;
      modulus  = 32'd1;
    endfunction

    function void set_config(logic [31:0] exp_val, logic [31:0] mod_val);
      exponent = exp_val;
      modulus  = mod_val;
    endfunction

    // pack the four digits, then right-to-left square-and-multiply
    function rbe_pkg::out_item_t encrypt(rbe_pkg::in_item_t item);
      logic [31:0]        codes;
      logic [7:0]         code;
      logic [63:0]        block;
      logic [63:0]        acc;
      logic [63:0]        sq;
      logic [63:0]        n;
      logic [31:0]        e;
      bit                 bad;
      rbe_pkg::out_item_t res;
      codes = item;
      block = '0;
      bad   = 1'b0;
      for (int i = rbe_pkg::DIGITS - 1; i >= 0; i--) begin
        code = codes[8*i +: 8];
        if (code < rbe_pkg::CHAR_OFFSET ||
            code > rbe_pkg::CHAR_OFFSET + rbe_pkg::DIGIT_BASE - 1)
          bad = 1'b1;
        else
          block = block * rbe_pkg::DIGIT_BASE + 64'(code - rbe_pkg::CHAR_OFFSET);
      end
      n = {32'b0, modulus};
      e = exponent;
      res.invalid_char = bad;
      if (bad) begin
        res.ciphertext = '0;
      end else if (e == 0) begin
        // zero exponent gives 1 even for modulus 0 or 1
        res.ciphertext = 32'd1;
      end else if (n == 0) begin
        res.ciphertext = '0;
      end else begin
        acc = 64'd1;
        sq  = block % n;
        while (e != 0) begin
          if (e[0]) acc = (acc * sq) % n;
          sq = (sq * sq) % n;
          e  = e >> 1;
        end
        res.ciphertext = 32'(acc % n);
      end
      return res;
    endfunction

    function void note_input(rbe_pkg::in_item_t item);
      expected_q = {expected_q, encrypt(item)};
      inputs_seen++;
    endfunction

    function void check_result(rbe_pkg::out_item_t got);
      rbe_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, ciphertext %h invalid_char %b",
                 $time, got.ciphertext, got.invalid_char);
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      if (got.ciphertext !== want.ciphertext) begin
        failures++;
        $display("%0t: ciphertext expected %h actual %h",
                 $time, want.ciphertext, got.ciphertext);
      end
      if (got.invalid_char !== want.invalid_char) begin
        failures++;
        $display("%0t: invalid_char expected %b actual %b",
                 $time, want.invalid_char, got.invalid_char);
      end
    endfunction

    function void check_empty();
      if (expected_q.size() != 0) begin
        failures++;
        $display("%0t: %0d results never arrived, first expected ciphertext %h",
                 $time, expected_q.size(), expected_q[0].ciphertext);
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [rbe_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [rbe_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  rbe_pkg::in_item_t              in_data_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  rbe_pkg::out_item_t             out_data_o;

  cipher_scoreboard board = new();
  int unsigned      cycle_count;

  rsa_block_encrypt_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a stuck handshake or a lost result ends here
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // result side: random back-pressure outside the steady window; every
  // accepted result is checked against the oldest prediction
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) board.check_result(out_data_o);
      out_ready_i <= (board.results_seen >= STEADY_LO && board.results_seen < STEADY_HI)
                     || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // offer one input transaction, with random idle cycles before it; valid
  // stays high after acceptance so back-to-back items need no extra edge
  task automatic send_item(rbe_pkg::in_item_t item);
    while (!(board.inputs_seen >= STEADY_LO && board.inputs_seen < STEADY_HI)
           && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(item);
  endtask

  // stop sending and wait until every predicted result has been taken;
  // always advances at least one edge so valid is not re-raised in this step
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.expected_q.size() != 0);
  endtask

  // every item yields one result, so a drained core is idle and safe to program
  task automatic reconfigure(logic [31:0] exp_val, logic [31:0] mod_val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= rbe_pkg::REG_PUBLIC_EXPONENT;
    cfg_wdata_i <= exp_val;
    @(posedge clk_i);
    cfg_idx_i   <= rbe_pkg::REG_MODULUS;
    cfg_wdata_i <= mod_val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_config(exp_val, mod_val);
  endtask

  // mostly well-formed blocks; some with one bad code, some fully random
  function automatic rbe_pkg::in_item_t random_item();
    logic [31:0] codes;
    int          slot;
    for (int i = 0; i < rbe_pkg::DIGITS; i++) codes[8*i +: 8] = 8'($urandom_range(65, 164));
    case ($urandom_range(0, 9))
      0: codes = $urandom;
      1: begin
        slot = $urandom_range(0, 3);
        codes[8*slot +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(0, 64))
                                                  : 8'($urandom_range(165, 255));
      end
      default: ;
    endcase
    return rbe_pkg::in_item_t'(codes);
  endfunction

  task automatic run_random(int count);
    for (int k = 0; k < count; k++) begin
      // hold the sender once mid-phase until the core has gone quiet
      if (count > 8 && k == count / 2) drain();
      send_item(random_item());
    end
  endtask

  initial begin
    logic [31:0] exp_val;
    logic [31:0] mod_val;
    int          count;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= rbe_pkg::REG_PUBLIC_EXPONENT;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: exponent 1, modulus 1, so valid blocks give 0
    send_item(rbe_pkg::in_item_t'(32'h41424344));
    send_item(rbe_pkg::in_item_t'(32'h40414141));

    // full-width modulus with the usual public exponent
    reconfigure(32'd65537, 32'hFFFF_FFFF);
    foreach (EDGE_CODES[i]) send_item(rbe_pkg::in_item_t'(EDGE_CODES[i]));

    // zero exponent with zero modulus still yields 1
    reconfigure(32'd0, 32'd0);
    send_item(rbe_pkg::in_item_t'(32'h41414141));
    send_item(rbe_pkg::in_item_t'(32'h41FF4141));

    // zero modulus with nonzero exponent yields 0
    reconfigure(32'd5, 32'd0);
    send_item(rbe_pkg::in_item_t'(32'h50515253));
    send_item(rbe_pkg::in_item_t'(32'hA4A4A4A4));

    // random phases; exponents stay narrow except in one short slow phase
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      count = 27;
      case (p)
        0: begin
          exp_val = 32'd3;
          mod_val = 32'd3233;
        end
        1: begin
          exp_val = 32'hFFFF_FFFF;
          mod_val = 32'hFFFF_FFFB;
          count   = 4;
        end
        2: begin
          exp_val = 32'd1;
          mod_val = $urandom;
        end
        3: begin
          exp_val = 32'd0;
          mod_val = $urandom;
        end
        4: begin
          exp_val = $urandom >> 20;
          mod_val = 32'd1;
        end
        5: begin
          exp_val = ($urandom >> 20) | 32'd1;
          mod_val = 32'd0;
        end
        default: begin
          exp_val = $urandom >> $urandom_range(20, 31);
          mod_val = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(2, 5000)) : $urandom;
        end
      endcase
      reconfigure(exp_val, mod_val);
      run_random(count);
    end

    // all stimulus is in: wait for the last results, then watch for strays
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    board.check_empty();
    if (board.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
src/rbe_pkg.sv
src/rbe_digit_pack.sv
src/rbe_modmul.sv
src/rsa_block_encrypt_core.sv
bench/rsa_block_encrypt_core_test.sv
